// ===== src/mtp_pkg.sv =====
package mtp_pkg;

  // Generator geometry.
  localparam int unsigned StateWords       = 624;
  localparam int unsigned RecurrenceOffset = 397;
  localparam int unsigned PosW             = 10;
  localparam logic [PosW-1:0] LastPos      = PosW'(StateWords - 1);
  localparam logic [PosW-1:0] FarWrap      = PosW'(StateWords - RecurrenceOffset);
  localparam logic [PosW-1:0] FarStep      = PosW'(RecurrenceOffset);

  // Recurrence and tempering constants.
  localparam logic [31:0] TwistConst = 32'h9908_b0df;
  localparam logic [31:0] HighBit    = 32'h8000_0000;
  localparam logic [31:0] LowBits    = 32'h7fff_ffff;
  localparam logic [31:0] TemperB    = 32'h9d2c_5680;
  localparam logic [31:0] TemperC    = 32'hefc6_0000;

  // Result buffer depth and the width of its credit counter.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned CreditW   = 3;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DRAW32 = 2'd1,
    CMD_DRAW64 = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_PREFETCH,
    OP_WORD,
    OP_LOAD
  } op_e;

  typedef enum logic [1:0] {
    KIND_SWEEP,
    KIND_HI,
    KIND_LO32,
    KIND_LO64
  } kind_e;

  // One operation handed from the sequencer to the datapath.
  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  pos;
    kind_e            kind;
    logic [31:0]      seed;
  } issue_t;

  // Clearing pass after reset.
  typedef struct packed {
    logic             active;
    logic [PosW-1:0]  addr;
  } clear_t;

  function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
    logic [PosW-1:0] r;
    r = (p == LastPos) ? '0 : p + PosW'(1);
    return r;
  endfunction

  function automatic logic [PosW-1:0] far_pos(input logic [PosW-1:0] p);
    logic [PosW-1:0] r;
    r = (p < FarWrap) ? p + FarStep : p - FarWrap;
    return r;
  endfunction

  // New state word from its own old value, its successor and the far word.
  function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                        input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (cur & HighBit) | (nxt & LowBits);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistConst;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== src/mtp_ram.sv =====
module mtp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, two registered read ports; a read in the cycle of a write
  // to the same entry returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/mtp_issue.sv =====
module mtp_issue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [9:0]                word_index_i,
  input  logic [31:0]               seed_word_i,
  input  logic                      out_pop_i,
  output mtp_pkg::issue_t           iss_o,
  output logic [mtp_pkg::PosW-1:0]  rd_addr_a_o,
  output logic [mtp_pkg::PosW-1:0]  rd_addr_b_o,
  output mtp_pkg::clear_t           clear_o
);

  import mtp_pkg::*;

  localparam logic [CreditW-1:0] CreditMax = CreditW'(FifoDepth);

  logic               clr_active_q;
  logic [PosW-1:0]    clr_addr_q;
  logic               req_valid_q;
  logic [1:0]         req_cmd_q;
  logic [9:0]         req_idx_q;
  logic [31:0]        req_seed_q;
  logic               half_q;
  logic [PosW-1:0]    cursor_q;
  logic               cache_valid_q;
  logic               prev_load_q;
  logic [CreditW-1:0] credit_q;
  logic [CreditW-1:0] credit_d;

  logic   want_word;
  logic   is_final;
  logic   done;
  logic   accept;
  kind_e  kind_sel;
  issue_t iss;

  // Decide what the held request does this cycle.
  always_comb begin
    want_word = 1'b0;
    is_final  = 1'b0;
    done      = 1'b0;
    kind_sel  = KIND_SWEEP;
    iss       = '{op: OP_IDLE, pos: cursor_q, kind: KIND_SWEEP, seed: req_seed_q};
    if (!clr_active_q && req_valid_q) begin
      case (cmd_e'(req_cmd_q))
        CMD_LOAD: begin
          if (req_idx_q > LastPos) begin
            done = 1'b1;
          end else if (cursor_q != '0) begin
            // Finish the pending regeneration before the word is replaced.
            want_word = 1'b1;
          end else begin
            iss.op  = OP_LOAD;
            iss.pos = req_idx_q;
            done    = 1'b1;
          end
        end
        CMD_DRAW32: begin
          want_word = 1'b1;
          is_final  = 1'b1;
          kind_sel  = KIND_LO32;
        end
        CMD_DRAW64: begin
          want_word = 1'b1;
          is_final  = half_q;
          kind_sel  = half_q ? KIND_LO64 : KIND_HI;
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
    if (want_word) begin
      if (!cache_valid_q) begin
        // The current word must be fetched first, but not while a load is
        // still being written.
        if (!prev_load_q) begin
          iss.op = OP_PREFETCH;
        end
      end else if (!is_final || credit_q != CreditMax) begin
        iss.op   = OP_WORD;
        iss.kind = kind_sel;
        done     = is_final;
      end
    end
  end

  // Read addresses for the word at the cursor.
  always_comb begin
    if (iss.op == OP_PREFETCH) begin
      rd_addr_a_o = cursor_q;
    end else begin
      rd_addr_a_o = next_pos(cursor_q);
    end
    rd_addr_b_o = far_pos(cursor_q);
  end

  assign in_stall_o = clr_active_q | (req_valid_q & ~done);
  assign accept     = in_valid_i & ~in_stall_o;
  assign iss_o      = iss;
  assign clear_o    = '{active: clr_active_q, addr: clr_addr_q};

  // Credits for results issued but not yet taken from the output buffer.
  always_comb begin
    credit_d = credit_q;
    if ((iss.op == OP_WORD) && is_final && !out_pop_i) begin
      credit_d = credit_q + CreditW'(1);
    end else if (!((iss.op == OP_WORD) && is_final) && out_pop_i) begin
      credit_d = credit_q - CreditW'(1);
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q  <= 1'b1;
      clr_addr_q    <= '0;
      req_valid_q   <= 1'b0;
      half_q        <= 1'b0;
      cursor_q      <= '0;
      cache_valid_q <= 1'b0;
      prev_load_q   <= 1'b0;
      credit_q      <= '0;
    end else begin
      if (clr_active_q) begin
        if (clr_addr_q == LastPos) begin
          clr_active_q <= 1'b0;
        end
        clr_addr_q <= clr_addr_q + PosW'(1);
      end
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (done) begin
        req_valid_q <= 1'b0;
      end
      if ((iss.op == OP_WORD) && (iss.kind == KIND_HI)) begin
        half_q <= 1'b1;
      end else if (done) begin
        half_q <= 1'b0;
      end
      if (iss.op == OP_WORD) begin
        cursor_q <= next_pos(cursor_q);
      end
      if (iss.op == OP_PREFETCH) begin
        cache_valid_q <= 1'b1;
      end else if (iss.op == OP_LOAD) begin
        cache_valid_q <= 1'b0;
      end
      prev_load_q <= (iss.op == OP_LOAD);
      credit_q    <= credit_d;
    end
  end

  // Request payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_cmd_q  <= cmd_i;
      req_idx_q  <= word_index_i;
      req_seed_q <= seed_word_i;
    end
  end

endmodule

// ===== src/mtp_datapath.sv =====
module mtp_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mtp_pkg::issue_t           iss_i,
  input  mtp_pkg::clear_t           clear_i,
  input  logic [31:0]               rd_data_a_i,
  input  logic [31:0]               rd_data_b_i,
  output logic                      wr_en_o,
  output logic [mtp_pkg::PosW-1:0]  wr_addr_o,
  output logic [31:0]               wr_data_o,
  output logic                      push_o,
  output logic [63:0]               push_data_o
);

  import mtp_pkg::*;

  issue_t      s1_q;
  logic [31:0] cur_q;
  logic [31:0] new_word;
  logic        s2_valid_q;
  kind_e       s2_kind_q;
  logic [31:0] s2_word_q;
  logic [31:0] hi_q;
  logic [31:0] tempered;

  // Regenerate the word whose neighbours arrive from memory this cycle.
  assign new_word = twist(cur_q, rd_data_a_i, rd_data_b_i);

  // Write port: clearing pass, regenerated word or loaded seed.
  always_comb begin
    wr_en_o   = 1'b0;
    wr_addr_o = s1_q.pos;
    wr_data_o = new_word;
    if (clear_i.active) begin
      wr_en_o   = 1'b1;
      wr_addr_o = clear_i.addr;
      wr_data_o = '0;
    end else if (s1_q.op == OP_WORD) begin
      wr_en_o = 1'b1;
    end else if (s1_q.op == OP_LOAD) begin
      wr_en_o   = 1'b1;
      wr_data_o = s1_q.seed;
    end
  end

  // Tempering and assembly of the result.
  assign tempered    = temper(s2_word_q);
  assign push_o      = s2_valid_q & ((s2_kind_q == KIND_LO32) | (s2_kind_q == KIND_LO64));
  assign push_data_o = (s2_kind_q == KIND_LO64) ? {hi_q, tempered} : {32'd0, tempered};

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '{op: OP_IDLE, pos: '0, kind: KIND_SWEEP, seed: '0};
      s2_valid_q <= 1'b0;
      s2_kind_q  <= KIND_SWEEP;
    end else begin
      s1_q       <= iss_i;
      s2_valid_q <= (s1_q.op == OP_WORD) && (s1_q.kind != KIND_SWEEP);
      s2_kind_q  <= s1_q.kind;
    end
  end

  // Word payload; the successor just read is the next word's own value.
  always_ff @(posedge clk_i) begin
    if ((s1_q.op == OP_PREFETCH) || (s1_q.op == OP_WORD)) begin
      cur_q <= rd_data_a_i;
    end
    s2_word_q <= new_word;
    if (s2_valid_q && (s2_kind_q == KIND_HI)) begin
      hi_q <= tempered;
    end
  end

endmodule

// ===== src/mtp_out_fifo.sv =====
module mtp_out_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [63:0] push_data_i,
  input  logic        pop_i,
  output logic        out_valid_o,
  output logic [63:0] out_data_o
);

  import mtp_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  logic [63:0]        buf_q [FifoDepth];
  logic [PtrW-1:0]    wr_ptr_q;
  logic [PtrW-1:0]    rd_ptr_q;
  logic [CreditW-1:0] count_q;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = buf_q[rd_ptr_q];

  // Pointers and fill level; the sequencer never overfills the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CreditW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CreditW'(1);
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/mersenne_twister_prng_top.sv =====
// MT19937 generator with its 624-word state held in one memory.
// Requests enter on in_valid_i/in_stall_o: cmd_i selects a state word load
// (word_index_i, seed_word_i), a 32-bit draw or a 64-bit draw (first output in
// the upper half). Each draw returns one result on out_valid_o/out_stall_i;
// loads and unused commands return nothing.
// The state is regenerated one word at a time as each word is drawn: every
// word needs two memory reads and one write, and the two read ports allow
// one word per cycle while the output buffer has room. A 64-bit draw
// regenerates two words. The first draw after a load or after reset first
// fetches the current word. A load arriving while a regeneration is part way
// done first completes it, one word per cycle. A result passes through the
// datapath registers and the output buffer before it appears. The four-entry
// output buffer lets requests keep flowing while the receiver stalls; once
// four results are issued and not yet taken, draws hold. After reset the
// memory is cleared one word at a time, during which requests are stalled;
// the state is then all zero and draws return zero.
module mersenne_twister_prng_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  word_index_i,
  input  logic [31:0] seed_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] random_value_o
);

  import mtp_pkg::*;

  issue_t          iss;
  clear_t          clear;
  logic [PosW-1:0] rd_addr_a;
  logic [PosW-1:0] rd_addr_b;
  logic [31:0]     rd_data_a;
  logic [31:0]     rd_data_b;
  logic            wr_en;
  logic [PosW-1:0] wr_addr;
  logic [31:0]     wr_data;
  logic            push;
  logic [63:0]     push_data;
  logic            out_pop;

  assign out_pop = out_valid_o & ~out_stall_i;

  // Request sequencer.
  mtp_issue u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .word_index_i (word_index_i),
    .seed_word_i  (seed_word_i),
    .out_pop_i    (out_pop),
    .iss_o        (iss),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b),
    .clear_o      (clear)
  );

  // State memory.
  mtp_ram #(
    .Width (32),
    .Depth (StateWords)
  ) u_state_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  // Recurrence, write-back and tempering.
  mtp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .clear_i     (clear),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Output buffer.
  mtp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (out_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (random_value_o)
  );

endmodule
